// ----- hdl/msup_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msup_pkg
// Shared types, codes and defaults of the motor channel supervisor.
// ----------------------------------------------------------------------------
package msup_pkg;

    // Fixed widths of the word fields
    localparam int FIELD_W     = 13;
    localparam int OP_W        = 3;
    localparam int CHAN_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_W     = 4;
    localparam int TIMEOUT_W   = 16;

    // Parameter defaults
    localparam int CHANNELS_DEF  = 13;
    localparam int TICK_BITS_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd1;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd2;
    localparam logic [OP_W-1:0] OP_HOME    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // Enable status codes
    localparam logic [STATUS_W-1:0] ST_NOT_LINKED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STALLED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMED_OUT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIL_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AWAY_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIME    = 3'd4;

    // Configuration reset values
    localparam logic [COUNT_W-1:0]   RST_CHANNEL_COUNT = 4'd13;
    localparam logic                 RST_COIL_MODE     = 1'b1;
    localparam logic [TIMEOUT_W-1:0] RST_HOME_TIMEOUT  = 16'd500;
    localparam logic [TIMEOUT_W-1:0] RST_AWAY_TIMEOUT  = 16'd800;
    localparam logic [TIMEOUT_W-1:0] RST_STALL_TIME    = 16'd100;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAN_W-1:0]  channel;
        logic [FIELD_W-1:0] link_level;
        logic [FIELD_W-1:0] position_level;
        logic [FIELD_W-1:0] rising_pulse;
        logic [FIELD_W-1:0] falling_pulse;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] enable_status;
        logic [FIELD_W-1:0]  link_mask;
        logic [FIELD_W-1:0]  position_mask;
        logic [FIELD_W-1:0]  enable_mask;
        logic [FIELD_W-1:0]  run_mask;
        logic [FIELD_W-1:0]  stall_mask;
        logic [FIELD_W-1:0]  timeout_mask;
        logic [FIELD_W-1:0]  error_mask;
        logic [FIELD_W-1:0]  drive_mask;
        logic                rising_flag;
        logic                falling_flag;
    } rsp_t;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [COUNT_W-1:0]   channel_count;
        logic                 coil_mode;
        logic [TIMEOUT_W-1:0] home_timeout;
        logic [TIMEOUT_W-1:0] away_timeout;
        logic [TIMEOUT_W-1:0] stall_time;
    } cfg_t;

    // Action decided for one channel during a scan step
    typedef struct packed {
        logic start;
        logic wr_elapsed;
        logic stop;
        logic set_stall;
        logic set_timeout;
    } chan_act_t;

endpackage

// ----- hdl/msup_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msup_req_if
// Request channel: valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface msup_req_if;
    logic          valid;
    logic          ready;
    msup_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/msup_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msup_rsp_if
// Response channel: valid/ready handshake carrying one status word.
// ----------------------------------------------------------------------------
interface msup_rsp_if;
    logic          valid;
    logic          ready;
    msup_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/msup_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msup_cfg
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module msup_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [msup_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msup_pkg::CFG_W-1:0]        cfg_wdata,
    output msup_pkg::cfg_t                    cfg
);

    msup_pkg::cfg_t cfg_reg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= msup_pkg::RST_CHANNEL_COUNT;
            cfg_reg.coil_mode     <= msup_pkg::RST_COIL_MODE;
            cfg_reg.home_timeout  <= msup_pkg::RST_HOME_TIMEOUT;
            cfg_reg.away_timeout  <= msup_pkg::RST_AWAY_TIMEOUT;
            cfg_reg.stall_time    <= msup_pkg::RST_STALL_TIME;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msup_pkg::REG_CHANNEL_COUNT:
                    cfg_reg.channel_count <= cfg_wdata[msup_pkg::COUNT_W-1:0];
                msup_pkg::REG_COIL_MODE:
                    cfg_reg.coil_mode <= cfg_wdata[0];
                msup_pkg::REG_HOME_TIMEOUT:
                    cfg_reg.home_timeout <= cfg_wdata[msup_pkg::TIMEOUT_W-1:0];
                msup_pkg::REG_AWAY_TIMEOUT:
                    cfg_reg.away_timeout <= cfg_wdata[msup_pkg::TIMEOUT_W-1:0];
                msup_pkg::REG_STALL_TIME:
                    cfg_reg.stall_time <= cfg_wdata[msup_pkg::TIMEOUT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/msup_chan_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msup_chan_unit
// Shared per-channel update unit: one tick counter increment and the stall
// and limit compares for the channel the scan currently visits.
// ----------------------------------------------------------------------------
module msup_chan_unit
#(
    parameter int TICK_BITS = msup_pkg::TICK_BITS_DEF
)
(
    input  logic                               en,
    input  logic                               run,
    input  logic                               rise,
    input  logic                               pos,
    input  msup_pkg::cfg_t                     cfg,
    input  logic [TICK_BITS-1:0]               elapsed,
    input  logic [TICK_BITS-1:0]               limit,
    output msup_pkg::chan_act_t                act,
    output logic [TICK_BITS-1:0]               elapsed_next,
    output logic [TICK_BITS-1:0]               limit_next
);

    localparam int TW = msup_pkg::TIMEOUT_W;

    logic [TICK_BITS-1:0]    sum;
    logic [TW-1:0]           start_limit;
    logic [TICK_BITS+TW-1:0] limit_ext;
    logic                    at_stall;
    logic                    at_limit;

    // Count one tick, wrapping at the counter width
    assign sum = elapsed + TICK_BITS'(1);

    // Pick the start limit and fit it to the counter width
    assign start_limit  = pos ? cfg.home_timeout : cfg.away_timeout;
    assign limit_ext    = {{TICK_BITS{1'b0}}, start_limit};
    assign limit_next   = limit_ext[TICK_BITS-1:0];
    assign elapsed_next = run ? sum : '0;

    // Compare at a width that holds both operands so no bits are lost
    assign at_stall = ({{TW{1'b0}}, sum} == {{TICK_BITS{1'b0}}, cfg.stall_time});
    assign at_limit = (sum == limit);

    // Decide start, stop and error flags for this channel
    always_comb
    begin
        act = '0;
        if (en)
        begin
            act.wr_elapsed = 1'b1;
            if (!run)
            begin
                act.start = 1'b1;
            end
            else if (rise)
            begin
                act.stop = 1'b1;
            end
            else if (at_stall && cfg.coil_mode)
            begin
                if (pos)
                begin
                    act.stop      = 1'b1;
                    act.set_stall = 1'b1;
                end
            end
            else if (at_limit)
            begin
                act.stop        = 1'b1;
                act.set_timeout = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/motor_channel_supervisor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_channel_supervisor_unit
// Supervises motor channels: link latch, edge flags, run timeouts and stalls.
// ----------------------------------------------------------------------------
// Every request word yields exactly one response word. Enable, disable, home,
// read-edges and unused ops go from acceptance straight to the response state.
// A tick with at least one channel enabled first scans N channels, where
// N = min(channel_count, CHANNELS): a single channel update unit (tick
// counter increment plus stall and limit compares) visits one channel per
// cycle. A tick with no channel enabled, or with channel_count of zero, skips
// the scan. The response sits in an output register, so a new request is
// taken while the previous response still waits. Configuration is to be
// written only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module motor_channel_supervisor_unit
#(
    parameter int CHANNELS  = msup_pkg::CHANNELS_DEF,
    parameter int TICK_BITS = msup_pkg::TICK_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    msup_req_if.sink                        req,
    msup_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [msup_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msup_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int FW    = msup_pkg::FIELD_W;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = 6;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Fit a word field to the channel vector
    function automatic logic [CHANNELS-1:0] to_chan(input logic [FW-1:0] f);
        logic [CHANNELS+FW-1:0] tmp;
        tmp = {{CHANNELS{1'b0}}, f};
        return tmp[CHANNELS-1:0];
    endfunction

    // Fit a channel vector into a word field
    function automatic logic [FW-1:0] to_field(input logic [CHANNELS-1:0] v);
        logic [CHANNELS+FW-1:0] tmp;
        tmp = {{FW{1'b0}}, v};
        return tmp[FW-1:0];
    endfunction

    msup_pkg::cfg_t      cfg;
    msup_pkg::chan_act_t act;

    logic [1:0]          state_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    last_reg;

    logic [CHANNELS-1:0] link_reg, pos_reg, rise_reg, fall_reg;
    logic [CHANNELS-1:0] en_reg, run_reg, stall_reg, tmo_reg, err_reg, drive_reg;

    logic [TICK_BITS-1:0] elapsed_reg [CHANNELS];
    logic [TICK_BITS-1:0] limit_reg   [CHANNELS];

    logic [msup_pkg::STATUS_W-1:0] status_reg;
    logic                          rf_reg;
    logic                          ff_reg;

    logic           rsp_valid_reg;
    msup_pkg::rsp_t rsp_data_reg;

    logic                 req_fire;
    logic                 ch_valid;
    logic [CHANNELS-1:0]  sel;
    logic [CHANNELS-1:0]  scan_bit;
    logic [CNT_W-1:0]     scan_n;
    logic [TICK_BITS-1:0] elapsed_next;
    logic [TICK_BITS-1:0] limit_next;
    logic                 load_rsp;

    msup_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msup_chan_unit #(.TICK_BITS(TICK_BITS)) u_chan
    (
        .en           (en_reg[idx_reg]),
        .run          (run_reg[idx_reg]),
        .rise         (rise_reg[idx_reg]),
        .pos          (pos_reg[idx_reg]),
        .cfg          (cfg),
        .elapsed      (elapsed_reg[idx_reg]),
        .limit        (limit_reg[idx_reg]),
        .act          (act),
        .elapsed_next (elapsed_next),
        .limit_next   (limit_next)
    );

    // Decode the request and the scan position
    assign req_fire = req.valid && req.ready;
    assign ch_valid = (32'(req.data.channel) < CHANNELS);
    assign sel      = ch_valid ? (CHANNELS'(1) << req.data.channel) : '0;
    assign scan_bit = CHANNELS'(1) << idx_reg;
    assign scan_n   = ({2'b00, cfg.channel_count} > CNT_W'(CHANNELS))
                      ? CNT_W'(CHANNELS) : {2'b00, cfg.channel_count};
    assign load_rsp = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);

    // Sequencer and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            last_reg   <= '0;
            link_reg   <= '0;
            pos_reg    <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            en_reg     <= '0;
            run_reg    <= '0;
            stall_reg  <= '0;
            tmo_reg    <= '0;
            err_reg    <= '0;
            drive_reg  <= '0;
            status_reg <= msup_pkg::ST_NOT_LINKED;
            rf_reg     <= 1'b0;
            ff_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        status_reg <= msup_pkg::ST_NOT_LINKED;
                        rf_reg     <= 1'b0;
                        ff_reg     <= 1'b0;
                        state_reg  <= S_DONE;
                        case (req.data.op)
                            msup_pkg::OP_TICK:
                            begin
                                if (en_reg == '0)
                                begin
                                    link_reg <= ~to_chan(req.data.link_level);
                                end
                                pos_reg  <= to_chan(req.data.position_level);
                                rise_reg <= rise_reg | to_chan(req.data.rising_pulse);
                                fall_reg <= fall_reg | to_chan(req.data.falling_pulse);
                                if ((en_reg != '0) && (scan_n != '0))
                                begin
                                    idx_reg   <= '0;
                                    last_reg  <= IDX_W'(scan_n - CNT_W'(1));
                                    state_reg <= S_SCAN;
                                end
                            end
                            msup_pkg::OP_ENABLE:
                            begin
                                if ((link_reg & sel) == '0)
                                begin
                                    status_reg <= msup_pkg::ST_NOT_LINKED;
                                end
                                else if ((stall_reg & sel) != '0)
                                begin
                                    status_reg <= msup_pkg::ST_STALLED;
                                end
                                else if ((tmo_reg & sel) != '0)
                                begin
                                    status_reg <= msup_pkg::ST_TIMED_OUT;
                                end
                                else
                                begin
                                    en_reg     <= en_reg | sel;
                                    status_reg <= msup_pkg::ST_ACCEPTED;
                                end
                            end
                            msup_pkg::OP_DISABLE:
                            begin
                                en_reg    <= en_reg & ~sel;
                                drive_reg <= drive_reg & ~sel;
                            end
                            msup_pkg::OP_HOME:
                            begin
                                en_reg <= en_reg | ~pos_reg;
                            end
                            msup_pkg::OP_READ:
                            begin
                                rf_reg   <= |(rise_reg & sel);
                                ff_reg   <= |(fall_reg & sel);
                                rise_reg <= rise_reg & ~sel;
                                fall_reg <= fall_reg & ~sel;
                            end
                            default:
                                ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // Apply the shared unit's decision to the visited channel
                    if (act.start)
                    begin
                        run_reg   <= run_reg | scan_bit;
                        rise_reg  <= rise_reg & ~scan_bit;
                        fall_reg  <= fall_reg & ~scan_bit;
                        drive_reg <= drive_reg | scan_bit;
                    end
                    if (act.stop)
                    begin
                        en_reg    <= en_reg & ~scan_bit;
                        run_reg   <= run_reg & ~scan_bit;
                        drive_reg <= drive_reg & ~scan_bit;
                    end
                    if (act.set_stall)
                    begin
                        stall_reg <= stall_reg | scan_bit;
                    end
                    if (act.set_timeout)
                    begin
                        tmo_reg <= tmo_reg | scan_bit;
                    end
                    if (act.set_stall || act.set_timeout)
                    begin
                        err_reg <= err_reg | scan_bit;
                    end
                    // Advance to the next channel or finish
                    if (idx_reg == last_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (load_rsp)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Tick counters and limits of the visited channel
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && act.wr_elapsed)
        begin
            elapsed_reg[idx_reg] <= elapsed_next;
        end
        if ((state_reg == S_SCAN) && act.start)
        begin
            limit_reg[idx_reg] <= limit_next;
        end
    end

    // Hold the response word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_data_reg.enable_status <= status_reg;
            rsp_data_reg.link_mask     <= to_field(link_reg);
            rsp_data_reg.position_mask <= to_field(pos_reg);
            rsp_data_reg.enable_mask   <= to_field(en_reg);
            rsp_data_reg.run_mask      <= to_field(run_reg);
            rsp_data_reg.stall_mask    <= to_field(stall_reg);
            rsp_data_reg.timeout_mask  <= to_field(tmo_reg);
            rsp_data_reg.error_mask    <= to_field(err_reg);
            rsp_data_reg.drive_mask    <= to_field(drive_reg);
            rsp_data_reg.rising_flag   <= rf_reg;
            rsp_data_reg.falling_flag  <= ff_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

// ----- hdl/msup_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msup_checker
// Port-level checks of the motor channel supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module msup_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input msup_pkg::rsp_t rsp_data
);

    // A stalled response word holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("response word changed while stalled");

    // One word at a time: no acceptance in the cycle after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted back to back");

    // Error flags are exactly the union of stall and timeout flags
    a_error_union: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.error_mask ==
                       (rsp_data.stall_mask | rsp_data.timeout_mask)))
        else $error("error mask differs from stall or timeout");

    // A driven motor is always enabled and running
    a_drive_subset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (((rsp_data.drive_mask & ~rsp_data.enable_mask) == '0) &&
                       ((rsp_data.drive_mask & ~rsp_data.run_mask) == '0)))
        else $error("drive on for a channel not enabled or not running");

endmodule

bind motor_channel_supervisor_unit msup_checker u_msup_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor channel supervisor. A queue-fed driver
// offers operation words, a monitor predicts each status word from a local
// copy of the supervisor state and compares it field by field on return.
// ----------------------------------------------------------------------------
module testbench;
    import msup_pkg::*;

    localparam int NCH        = CHANNELS_DEF;
    localparam int TICK_W     = TICK_BITS_DEF;
    localparam int HOLD_LEN   = 300;
    localparam int PHASE_LEN  = 85;
    localparam logic [FIELD_W-1:0] ALL_CH = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    msup_req_if req_bus ();
    msup_rsp_if rsp_bus ();

    motor_channel_supervisor_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Words waiting to be offered, status words waiting to come back
    req_t pending_words [$];
    rsp_t expected_status [$];

    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_asks;
    int   fail_count;
    logic word_taken;

    // Local copy of the supervisor configuration and state
    logic [COUNT_W-1:0]   cfg_count;
    logic                 cfg_coil;
    logic [TIMEOUT_W-1:0] cfg_home;
    logic [TIMEOUT_W-1:0] cfg_away;
    logic [TIMEOUT_W-1:0] cfg_stall;
    logic [FIELD_W-1:0]   link_q, pos_q, rise_q, fall_q;
    logic [FIELD_W-1:0]   en_q, run_q, stall_q, tmo_q, err_q, drv_q;
    logic [TICK_W-1:0]    elapsed_cnt [NCH];
    logic [TICK_W-1:0]    limit_cnt [NCH];

    // Apply one operation word to the local state, return the status word
    function automatic rsp_t supervise_word(input req_t w);
        rsp_t               r;
        logic [FIELD_W-1:0] sel;
        logic [FIELD_W-1:0] b;
        logic               halt;
        int                 n;
        r = '0;
        sel = '0;
        if (w.channel < NCH)
            sel[w.channel] = 1'b1;
        r.enable_status = ST_NOT_LINKED;
        case (w.op)
            OP_TICK:
            begin
                // links follow the inputs only while nothing is enabled
                if (en_q == '0)
                    link_q = ~w.link_level;
                pos_q = w.position_level;
                fall_q |= w.falling_pulse;
                rise_q |= w.rising_pulse;
                if (en_q != '0)
                begin
                    n = (cfg_count > NCH) ? NCH : int'(cfg_count);
                    for (int i = 0; i < n; i++)
                    begin
                        b = '0;
                        b[i] = 1'b1;
                        halt = 1'b0;
                        if ((en_q & b) != '0)
                        begin
                            if ((run_q & b) == '0)
                            begin
                                // start: pick limit from home position
                                limit_cnt[i] = ((pos_q & b) != '0) ? cfg_home : cfg_away;
                                run_q |= b;
                                rise_q &= ~b;
                                fall_q &= ~b;
                                elapsed_cnt[i] = '0;
                                drv_q |= b;
                            end
                            else
                            begin
                                elapsed_cnt[i] = elapsed_cnt[i] + 1'b1;
                                if ((rise_q & b) != '0)
                                    halt = 1'b1;
                                else if (elapsed_cnt[i] == cfg_stall && cfg_coil)
                                begin
                                    // stall tick: released switch skips the limit check
                                    if ((pos_q & b) != '0)
                                    begin
                                        stall_q |= b;
                                        err_q |= b;
                                        halt = 1'b1;
                                    end
                                end
                                else if (elapsed_cnt[i] == limit_cnt[i])
                                begin
                                    tmo_q |= b;
                                    err_q |= b;
                                    halt = 1'b1;
                                end
                            end
                            if (halt)
                            begin
                                en_q &= ~b;
                                run_q &= ~b;
                                drv_q &= ~b;
                            end
                        end
                    end
                end
            end
            OP_ENABLE:
            begin
                if ((link_q & sel) == '0)
                    r.enable_status = ST_NOT_LINKED;
                else if ((stall_q & sel) != '0)
                    r.enable_status = ST_STALLED;
                else if ((tmo_q & sel) != '0)
                    r.enable_status = ST_TIMED_OUT;
                else
                begin
                    en_q |= sel;
                    r.enable_status = ST_ACCEPTED;
                end
            end
            OP_DISABLE:
            begin
                // run bit is left alone on purpose
                en_q &= ~sel;
                drv_q &= ~sel;
            end
            OP_HOME:
                en_q |= ~pos_q;
            OP_READ:
            begin
                r.rising_flag = |(rise_q & sel);
                r.falling_flag = |(fall_q & sel);
                rise_q &= ~sel;
                fall_q &= ~sel;
            end
            default:
                ;
        endcase
        r.link_mask = link_q;
        r.position_mask = pos_q;
        r.enable_mask = en_q;
        r.run_mask = run_q;
        r.stall_mask = stall_q;
        r.timeout_mask = tmo_q;
        r.error_mask = err_q;
        r.drive_mask = drv_q;
        return r;
    endfunction

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_status(input rsp_t want, input rsp_t got);
        check_field("enable_status", want.enable_status, got.enable_status);
        check_field("link_mask", want.link_mask, got.link_mask);
        check_field("position_mask", want.position_mask, got.position_mask);
        check_field("enable_mask", want.enable_mask, got.enable_mask);
        check_field("run_mask", want.run_mask, got.run_mask);
        check_field("stall_mask", want.stall_mask, got.stall_mask);
        check_field("timeout_mask", want.timeout_mask, got.timeout_mask);
        check_field("error_mask", want.error_mask, got.error_mask);
        check_field("drive_mask", want.drive_mask, got.drive_mask);
        check_field("rising_flag", want.rising_flag, got.rising_flag);
        check_field("falling_flag", want.falling_flag, got.falling_flag);
    endtask

    function automatic logic [FIELD_W-1:0] sparse_bits(input int pct);
        logic [FIELD_W-1:0] v;
        for (int i = 0; i < FIELD_W; i++)
            v[i] = ($urandom_range(0, 99) < pct);
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] any_bits();
        return FIELD_W'($urandom_range(0, (1 << FIELD_W) - 1));
    endfunction

    function automatic req_t random_word();
        req_t w;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            w.op = OP_TICK;
        else if (pick < 65)
            w.op = OP_ENABLE;
        else if (pick < 75)
            w.op = OP_DISABLE;
        else if (pick < 80)
            w.op = OP_HOME;
        else if (pick < 93)
            w.op = OP_READ;
        else
            w.op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
        if ($urandom_range(0, 9) == 0)
            w.channel = CHAN_W'($urandom_range(NCH, (1 << CHAN_W) - 1));
        else
            w.channel = CHAN_W'($urandom_range(0, NCH - 1));
        w.link_level = ($urandom_range(0, 4) == 0) ? any_bits() : sparse_bits(15);
        w.position_level = ($urandom_range(0, 9) == 0) ? any_bits() : sparse_bits(30);
        w.rising_pulse = ($urandom_range(0, 19) == 0) ? any_bits() : sparse_bits(8);
        w.falling_pulse = ($urandom_range(0, 9) == 0) ? any_bits() : sparse_bits(20);
        return w;
    endfunction

    task automatic put_word(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                            input logic [FIELD_W-1:0] link, input logic [FIELD_W-1:0] pos,
                            input logic [FIELD_W-1:0] rise, input logic [FIELD_W-1:0] fall);
        req_t w;
        w.op = op;
        w.channel = ch;
        w.link_level = link;
        w.position_level = pos;
        w.rising_pulse = rise;
        w.falling_pulse = fall;
        pending_words.push_back(w);
    endtask

    // Wait until every word is out and answered, then let the scan drain
    task automatic settle();
        while (pending_words.size() != 0 || req_bus.valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (NCH + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CHANNEL_COUNT: cfg_count = value[COUNT_W-1:0];
            REG_COIL_MODE:     cfg_coil = value[0];
            REG_HOME_TIMEOUT:  cfg_home = value[TIMEOUT_W-1:0];
            REG_AWAY_TIMEOUT:  cfg_away = value[TIMEOUT_W-1:0];
            REG_STALL_TIME:    cfg_stall = value[TIMEOUT_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic set_config(input int count, input int coil, input int home,
                              input int away, input int stall);
        write_reg(REG_CHANNEL_COUNT, CFG_W'(count));
        write_reg(REG_COIL_MODE, CFG_W'(coil));
        write_reg(REG_HOME_TIMEOUT, CFG_W'(home));
        write_reg(REG_AWAY_TIMEOUT, CFG_W'(away));
        write_reg(REG_STALL_TIME, CFG_W'(stall));
    endtask

    task automatic run_random(input int words, input int send_pct, input int recv_pct,
                              input bit squeeze);
        req_t w;
        int   count;
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        count = 0;
        while (count < words)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                // drop every channel so the next tick relatches the links
                for (int c = 0; c < NCH; c++)
                    put_word(OP_DISABLE, CHAN_W'(c), '0, '0, '0, '0);
                put_word(OP_TICK, '0, any_bits(), sparse_bits(30), sparse_bits(8),
                         sparse_bits(20));
                count += NCH + 1;
            end
            else
            begin
                w = random_word();
                pending_words.push_back(w);
                if (w.op <= OP_READ)
                    count++;
            end
        end
        if (squeeze)
            hold_asks++;
        settle();
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("motor_channel_supervisor_unit test failed");
        $finish;
    end

    // Offer words at the falling edge, hold until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (req_bus.valid && !word_taken)
            req_bus.valid <= 1'b1;
        else if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            req_bus.data <= pending_words.pop_front();
            req_bus.valid <= 1'b1;
        end
        else
            req_bus.valid <= 1'b0;
    end

    // Receiver ready, with an occasional long hold-off
    always @(negedge clk)
    begin : ready_gen
        int hold_left;
        int hold_seen;
        if (hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on accepted words, check returned status words
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
                expected_status.push_back(supervise_word(req_bus.data));
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: status word with none expected, actual %0h", $time,
                             rsp_bus.data);
                    fail_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    compare_status(want, rsp_bus.data);
                end
            end
        end
        word_taken <= req_bus.valid && req_bus.ready;
    end

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        rsp_bus.ready = 1'b0;
        word_taken = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 60;
        hold_asks = 0;
        fail_count = 0;
        cfg_count = RST_CHANNEL_COUNT;
        cfg_coil = RST_COIL_MODE;
        cfg_home = RST_HOME_TIMEOUT;
        cfg_away = RST_AWAY_TIMEOUT;
        cfg_stall = RST_STALL_TIME;
        {link_q, pos_q, rise_q, fall_q} = '0;
        {en_q, run_q, stall_q, tmo_q, err_q, drv_q} = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sampling, bad indexes, unused ops, stall, timeout, resume
        set_config(NCH, 1, 4, 6, 3);
        @(posedge clk);
        put_word(OP_TICK, 0, '0, '0, ALL_CH, ALL_CH);
        put_word(OP_READ, 5, '0, '0, '0, '0);
        put_word(OP_READ, NCH, '0, '0, '0, '0);
        put_word(OP_ENABLE, 15, '0, '0, '0, '0);
        put_word(OP_DISABLE, 14, '0, '0, '0, '0);
        for (int k = int'(OP_READ) + 1; k < (1 << OP_W); k++)
            put_word(OP_W'(k), 0, ALL_CH, ALL_CH, ALL_CH, ALL_CH);
        put_word(OP_ENABLE, 1, '0, '0, '0, '0);
        put_word(OP_ENABLE, 2, '0, '0, '0, '0);
        put_word(OP_ENABLE, 3, '0, '0, '0, '0);
        put_word(OP_TICK, 0, ALL_CH, 13'h0002, '0, '0);
        put_word(OP_TICK, 0, ALL_CH, 13'h0002, '0, '0);
        put_word(OP_DISABLE, 3, '0, '0, '0, '0);
        put_word(OP_TICK, 0, ALL_CH, 13'h0002, '0, '0);
        put_word(OP_ENABLE, 3, '0, '0, '0, '0);
        for (int k = 0; k < 4; k++)
            put_word(OP_TICK, 0, ALL_CH, 13'h0002, '0, '0);
        put_word(OP_TICK, 0, ALL_CH, 13'h0002, 13'h0008, '0);
        put_word(OP_ENABLE, 1, '0, '0, '0, '0);
        put_word(OP_ENABLE, 2, '0, '0, '0, '0);
        put_word(OP_READ, 3, '0, '0, '0, '0);
        put_word(OP_HOME, 0, '0, '0, '0, '0);
        settle();

        // Random phases across settings and idling modes
        set_config(NCH, 1, 1, 7, 4);
        run_random(PHASE_LEN, 26, 60, 1'b0);
        set_config(0, 0, 9, 12, 65535);
        run_random(PHASE_LEN, 26, 60, 1'b0);
        set_config(7, 1, 65535, 65535, 2);
        run_random(PHASE_LEN, 60, 26, 1'b0);
        set_config(15, 1, 6, 10, 3);
        run_random(PHASE_LEN, 60, 26, 1'b1);
        set_config(NCH, 1, 20, 30, 8);
        run_random(PHASE_LEN, 0, 0, 1'b0);
        set_config(14, 0, 1, 1, 1);
        run_random(PHASE_LEN, 0, 0, 1'b0);

        if (fail_count == 0)
            $display("motor_channel_supervisor_unit test passed");
        else
            $display("motor_channel_supervisor_unit test failed");
        $finish;
    end

endmodule
